FILE: src/edfq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// EDF ready queue package
// Shared widths, command and status codes, cell entry type and cell control
// for the ready queue chain.
// ----------------------------------------------------------------------------
package edfq_pkg;

   localparam int QUEUE_SLOTS_DEF = 16;
   localparam int TID_W           = 15;
   localparam int DL_W            = 32;
   localparam int CMD_W           = 2;
   localparam int STATUS_W        = 2;
   localparam int COUNT_OUT_W     = 5;

   localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PICK = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DUP    = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_FROM_ABOVE,
      CELL_FROM_BELOW
   } cell_op_type;

   typedef struct packed {
      logic             valid;
      logic [TID_W-1:0] tid;
      logic [DL_W-1:0]  deadline;
   } cell_type;

   typedef struct packed {
      cell_op_type      op;
      logic [TID_W-1:0] key;
   } cell_ctl_type;

endpackage
`default_nettype wire

FILE: src/edf_ready_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// EDF ready queue unit
// Earliest-deadline-first ready queue built as a chain of slot cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req_    | in        | req_valid/stall   | command, task_id, deadline
//  rsp_    | out       | rsp_valid/stall   | status, picked_*, nearest, count
//
//  Enqueue and unused command pass the check, decide and done states. Dequeue of
//  a queued id adds a shift state and a scan; pick adds a scan, whose length is
//  set by one full rotation of the cell chain past the head cell.
//  Reset clears the valid bit of every cell and the count, and sets the nearest
//  deadline to all ones. The result register holds while rsp_stall is high;
//  the next request is taken while the previous result waits.
// ----------------------------------------------------------------------------
module edf_ready_queue_unit #(
   parameter int QUEUE_SLOTS = edfq_pkg::QUEUE_SLOTS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [edfq_pkg::CMD_W-1:0]        req_command,
   input  wire  [edfq_pkg::TID_W-1:0]        req_task_id,
   input  wire  [edfq_pkg::DL_W-1:0]         req_deadline,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [edfq_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_picked_valid,
   output logic [edfq_pkg::TID_W-1:0]        rsp_picked_task,
   output logic [edfq_pkg::DL_W-1:0]         rsp_nearest_deadline,
   output logic [edfq_pkg::COUNT_OUT_W-1:0]  rsp_running_count
);
   import edfq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_SLOTS + 1);
   localparam int IDX_W = $clog2(QUEUE_SLOTS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DECIDE,
      S_SHIFT,
      S_SCAN,
      S_DONE
   } state_type;

   state_type              state_ff;
   logic [CMD_W-1:0]       cmd_ff;
   logic [TID_W-1:0]       key_id_ff;
   logic [DL_W-1:0]        key_dl_ff;
   logic [QUEUE_SLOTS-1:0] hit_id_ff;
   logic [IDX_W-1:0]       sel_ff;
   logic [IDX_W-1:0]       rot_ff;
   logic [DL_W-1:0]        best_ff;
   logic                   found_ff;
   logic [TID_W-1:0]       ptask_ff;
   logic [DL_W-1:0]        nearest_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [STATUS_W-1:0]    status_ff;

   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic                   rsp_pvalid_ff;
   logic [TID_W-1:0]       rsp_ptask_ff;
   logic [DL_W-1:0]        rsp_nearest_ff;
   logic [CNT_W-1:0]       rsp_count_ff;

   cell_ctl_type           ctl      [QUEUE_SLOTS];
   cell_type               above    [QUEUE_SLOTS];
   cell_type               below    [QUEUE_SLOTS];
   cell_type               entry    [QUEUE_SLOTS];
   logic [QUEUE_SLOTS-1:0] id_hit;
   logic [QUEUE_SLOTS-1:0] valid_vec;

   cell_type               new_entry;
   cell_type               tail_fill;
   cell_type               head;
   logic                   any_id;
   logic                   is_full;
   logic                   do_push;
   logic [IDX_W-1:0]       sel_in;
   logic [DL_W-1:0]        best_in;
   logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

   assign any_id  = |hit_id_ff;
   assign is_full = (count_ff == CNT_W'(QUEUE_SLOTS));
   assign do_push = (state_ff == S_DECIDE) && (cmd_ff == CMD_ENQ) && !any_id && !is_full;
   assign head    = entry[0];

   assign new_entry.valid    = 1'b1;
   assign new_entry.tid      = key_id_ff;
   assign new_entry.deadline = key_dl_ff;

   // ids are unique, so the match vector has at most one bit set and encodes by OR
   always_comb begin
      sel_in = '0;
      for (int b = 0; b < IDX_W; b++) begin
         for (int i = 0; i < QUEUE_SLOTS; i++) begin
            if (((i >> b) & 1) == 1) begin
               sel_in[b] = sel_in[b] | hit_id_ff[i];
            end
         end
      end
   end

   always_comb begin
      if (state_ff == S_SCAN) begin
         tail_fill = entry[0];
      end else begin
         tail_fill = '0;
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
         ctl[i].key = key_id_ff;
         ctl[i].op  = CELL_HOLD;
         case (state_ff)
            S_DECIDE: begin
               if (do_push) begin
                  ctl[i].op = CELL_FROM_ABOVE;
               end
            end
            S_SHIFT: begin
               if (IDX_W'(i) >= sel_ff) begin
                  ctl[i].op = CELL_FROM_BELOW;
               end
            end
            S_SCAN: begin
               ctl[i].op = CELL_FROM_BELOW;
            end
            default: begin
               ctl[i].op = CELL_HOLD;
            end
         endcase
         above[i]     = (i == 0) ? new_entry : entry[(i == 0) ? 0 : i - 1];
         below[i]     = (i == QUEUE_SLOTS - 1) ? tail_fill
                        : entry[(i == QUEUE_SLOTS - 1) ? i : i + 1];
         valid_vec[i] = entry[i].valid;
      end
   end

   for (genvar g = 0; g < QUEUE_SLOTS; g++) begin : g_cell
      edfq_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl[g]),
         .above  (above[g]),
         .below  (below[g]),
         .entry  (entry[g]),
         .id_hit (id_hit[g])
      );
   end

   assign best_in = (head.valid && (head.deadline < best_ff)) ? head.deadline : best_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nearest_ff   <= '1;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff    <= req_command;
                  key_id_ff <= req_task_id;
                  key_dl_ff <= req_deadline;
                  found_ff  <= 1'b0;
                  ptask_ff  <= '0;
                  status_ff <= ST_OK;
                  state_ff  <= S_CHECK;
               end
            end
            S_CHECK: begin
               hit_id_ff <= id_hit;
               state_ff  <= S_DECIDE;
            end
            S_DECIDE: begin
               rot_ff  <= '0;
               best_ff <= '1;
               sel_ff  <= sel_in;
               case (cmd_ff)
                  CMD_ENQ: begin
                     state_ff <= S_DONE;
                     if (any_id) begin
                        status_ff <= ST_DUP;
                     end else if (is_full) begin
                        status_ff <= ST_FULL;
                     end else begin
                        count_ff <= count_ff + 1'b1;
                        if (key_dl_ff < nearest_ff) begin
                           nearest_ff <= key_dl_ff;
                        end
                     end
                  end
                  CMD_DEQ: begin
                     if (any_id) begin
                        state_ff <= S_SHIFT;
                     end else begin
                        status_ff <= ST_ABSENT;
                        state_ff  <= S_DONE;
                     end
                  end
                  CMD_PICK: begin
                     state_ff <= S_SCAN;
                  end
                  default: begin
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_SHIFT: begin
               if (count_ff != '0) begin
                  count_ff <= count_ff - 1'b1;
               end
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               best_ff <= best_in;
               rot_ff  <= rot_ff + 1'b1;
               if ((cmd_ff == CMD_PICK) && !found_ff && head.valid &&
                   (head.deadline == nearest_ff)) begin
                  found_ff <= 1'b1;
                  ptask_ff <= head.tid;
               end
               if (rot_ff == IDX_W'(QUEUE_SLOTS - 1)) begin
                  if (cmd_ff == CMD_DEQ) begin
                     nearest_ff <= best_in;
                  end
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= status_ff;
                  rsp_pvalid_ff  <= found_ff;
                  rsp_ptask_ff   <= found_ff ? ptask_ff : '0;
                  rsp_nearest_ff <= nearest_ff;
                  rsp_count_ff   <= count_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign count_ext = {{COUNT_OUT_W{1'b0}}, rsp_count_ff};

   assign req_stall            = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_picked_valid     = rsp_pvalid_ff;
   assign rsp_picked_task      = rsp_ptask_ff;
   assign rsp_nearest_deadline = rsp_nearest_ff;
   assign rsp_running_count    = count_ext[COUNT_OUT_W-1:0];

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_SLOTS))
      else $error("queued count above slot count");

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> $countones(valid_vec) == 32'(count_ff))
      else $error("queued count disagrees with valid cells");

   a_unique_ids: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DECIDE |-> $onehot0(hit_id_ff))
      else $error("task id held in more than one cell");

   a_packed_list: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && !valid_vec[0] |-> valid_vec == '0)
      else $error("live entries not packed at the head");
`endif

endmodule
`default_nettype wire

FILE: src/edfq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// EDF ready queue cell
// One slot of the chain: holds an entry, loads from either neighbor, and
// flags an id match against the broadcast key.
// ----------------------------------------------------------------------------
module edfq_cell (
   input  wire                         clock,
   input  wire                         reset,
   input  wire edfq_pkg::cell_ctl_type ctl,
   input  wire edfq_pkg::cell_type     above,
   input  wire edfq_pkg::cell_type     below,
   output edfq_pkg::cell_type          entry,
   output logic                        id_hit
);
   import edfq_pkg::*;

   cell_type entry_ff;
   cell_type entry_in;

   always_comb begin
      case (ctl.op)
         CELL_HOLD:       entry_in = entry_ff;
         CELL_FROM_ABOVE: entry_in = above;
         CELL_FROM_BELOW: entry_in = below;
         default:         entry_in = entry_ff;
      endcase
      if (reset) begin
         entry_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry  = entry_ff;
   assign id_hit = entry_ff.valid && (entry_ff.tid == ctl.key);

endmodule
`default_nettype wire

FILE: tb/tb_edf_ready_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF ready queue unit testbench
// Directed and random enqueue, dequeue and pick traffic against a local model
// of the ready task list, newest first. Each result is compared field by field.
// Both channels take random gaps. One phase holds off the result side long
// enough to fill the block.
// ----------------------------------------------------------------------------
module tb_edf_ready_queue_unit;
   import edfq_pkg::*;

   localparam int SLOTS = QUEUE_SLOTS_DEF;

   localparam logic [CMD_W-1:0] CMD_ENQUEUE = CMD_ENQ,
                                CMD_DEQUEUE = CMD_DEQ,
                                CMD_UNUSED  = CMD_NONE;

   localparam logic [STATUS_W-1:0] STAT_OK        = ST_OK,
                                   STAT_FULL      = ST_FULL,
                                   STAT_ABSENT    = ST_ABSENT,
                                   STAT_DUPLICATE = ST_DUP;

   localparam logic [DL_W-1:0] NO_DEADLINE = '1;
   localparam int DRAIN_CYCLES    = SLOTS + 12;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic                   picked_valid;
      logic [TID_W-1:0]       picked_task;
      logic [DL_W-1:0]        nearest;
      logic [COUNT_OUT_W-1:0] count;
   } queue_report_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [CMD_W-1:0]       req_command;
   logic [TID_W-1:0]       req_task_id;
   logic [DL_W-1:0]        req_deadline;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   rsp_picked_valid;
   logic [TID_W-1:0]       rsp_picked_task;
   logic [DL_W-1:0]        rsp_nearest_deadline;
   logic [COUNT_OUT_W-1:0] rsp_running_count;

   // model of the ready list: live entries are 0 .. ready_count-1, head first
   logic [TID_W-1:0] ready_tid [SLOTS];
   logic [DL_W-1:0]  ready_dl  [SLOTS];
   int               ready_count;
   logic [DL_W-1:0]  ready_nearest;

   queue_report_type pending_reports [$];
   int               fail_count;
   bit               idle_on;
   bit               hold_off_req;

   edf_ready_queue_unit #(
      .QUEUE_SLOTS(SLOTS)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_task_id          (req_task_id),
      .req_deadline         (req_deadline),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_picked_valid     (rsp_picked_valid),
      .rsp_picked_task      (rsp_picked_task),
      .rsp_nearest_deadline (rsp_nearest_deadline),
      .rsp_running_count    (rsp_running_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int find_ready(input logic [TID_W-1:0] id);
      for (int i = 0; i < ready_count; i++)
         if (ready_tid[i] == id) return i;
      return -1;
   endfunction

   function automatic queue_report_type edf_apply(input logic [CMD_W-1:0] cmd,
                                                  input logic [TID_W-1:0] id,
                                                  input logic [DL_W-1:0] dl);
      queue_report_type r;
      int pos;
      r = '0;
      r.status = STAT_OK;
      case (cmd)
         CMD_ENQUEUE: begin
            if (find_ready(id) >= 0) begin
               r.status = STAT_DUPLICATE;
            end else if (ready_count >= SLOTS) begin
               r.status = STAT_FULL;
            end else begin
               for (int i = SLOTS - 1; i > 0; i--) begin
                  ready_tid[i] = ready_tid[i-1];
                  ready_dl[i]  = ready_dl[i-1];
               end
               ready_tid[0] = id;
               ready_dl[0]  = dl;
               if (dl < ready_nearest) ready_nearest = dl;
               ready_count++;
            end
         end
         CMD_DEQUEUE: begin
            pos = find_ready(id);
            if (pos < 0) begin
               r.status = STAT_ABSENT;
            end else begin
               for (int i = pos; i < SLOTS - 1; i++) begin
                  ready_tid[i] = ready_tid[i+1];
                  ready_dl[i]  = ready_dl[i+1];
               end
               ready_count--;
               ready_nearest = NO_DEADLINE;
               for (int i = 0; i < ready_count; i++)
                  if (ready_dl[i] < ready_nearest) ready_nearest = ready_dl[i];
            end
         end
         CMD_PICK: begin
            for (int i = 0; i < ready_count && !r.picked_valid; i++) begin
               if (ready_dl[i] == ready_nearest) begin
                  r.picked_valid = 1'b1;
                  r.picked_task  = ready_tid[i];
               end
            end
         end
         default: ;
      endcase
      r.nearest = ready_nearest;
      r.count   = COUNT_OUT_W'(ready_count);
      return r;
   endfunction

   function automatic string format_report(input queue_report_type r);
      return $sformatf("status=%0d picked=%0d task=%0d nearest=%h count=%0d",
                       r.status, r.picked_valid, r.picked_task, r.nearest, r.count);
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%0t: mismatch: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : check_reports
      queue_report_type got;
      queue_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_status, rsp_picked_valid, rsp_picked_task,
                rsp_nearest_deadline, rsp_running_count};
         if (pending_reports.size() == 0) begin
            note_failure({"result with none pending: ", format_report(got)});
         end else begin
            want = pending_reports.pop_front();
            if (got !== want)
               note_failure({"expected ", format_report(want),
                             " got ", format_report(got)});
         end
      end
   end

   // gap lengths: mostly none or short, a few long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int sender_gap();
      return idle_on ? idle_length() : 0;
   endfunction

   initial begin : drive_rsp_stall
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            for (n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 99) < 30) begin
            n = idle_length() + 1;
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TID_W-1:0] id,
                            input logic [DL_W-1:0] dl, input int gap);
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_task_id  <= id;
      req_deadline <= dl;
      do @(posedge clock); while (req_stall);
      pending_reports.push_back(edf_apply(cmd, id, dl));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_reports_drained();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [TID_W-1:0] pick_task_id(input logic [CMD_W-1:0] cmd);
      int r;
      r = $urandom_range(0, 99);
      if (ready_count > 0 && ((cmd == CMD_DEQUEUE && r < 85) || (cmd == CMD_ENQUEUE && r < 8)))
         return ready_tid[$urandom_range(0, ready_count - 1)];
      if ($urandom_range(0, 99) < 40) return TID_W'($urandom_range(0, 31));
      return TID_W'($urandom_range(0, 2**TID_W - 1));
   endfunction

   function automatic logic [DL_W-1:0] pick_deadline();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom();
      if (r < 65) return DL_W'($urandom_range(1000, 1007));
      if (r < 75) return ($urandom_range(0, 1) != 0) ? NO_DEADLINE : '0;
      if (r < 90 && ready_nearest != NO_DEADLINE)
         return ready_nearest + DL_W'($urandom_range(0, 2)) - 1'b1;
      return NO_DEADLINE - DL_W'($urandom_range(0, 3));
   endfunction

   task automatic test_empty_queue();
      send_item(CMD_PICK, '0, '0, 0);
      send_item(CMD_DEQUEUE, 15'd5, '0, 1);
      send_item(CMD_UNUSED, '1, '1, 0);
   endtask

   task automatic test_fill_and_overflow();
      send_item(CMD_ENQUEUE, '1, NO_DEADLINE, 0);
      send_item(CMD_PICK, '0, '0, 0);
      send_item(CMD_ENQUEUE, '1, '0, 2);
      send_item(CMD_ENQUEUE, 15'd0, '0, 0);
      send_item(CMD_ENQUEUE, 15'd1, '0, 0);
      for (int i = 2; i < 14; i++)
         send_item(CMD_ENQUEUE, TID_W'(i),
                   (i % 2) ? 32'h8000_0000 + i : 32'h7FFF_FFFF - i, i % 3);
      send_item(CMD_ENQUEUE, 15'd20, 32'd7, 0);
      send_item(CMD_ENQUEUE, 15'd21, 32'd1, 0);
      // duplicate wins over full
      send_item(CMD_ENQUEUE, 15'd0, 32'd5, 0);
   endtask

   task automatic test_pick_order();
      send_item(CMD_PICK, '0, '0, 0);
      send_item(CMD_DEQUEUE, 15'd1, '0, 0);
      send_item(CMD_PICK, '0, '0, 1);
      send_item(CMD_DEQUEUE, 15'd0, '0, 0);
      send_item(CMD_PICK, '0, '0, 0);
      send_item(CMD_UNUSED, 15'h2AAA, 32'h5555_5555, 0);
      wait_reports_drained();
   endtask

   task automatic test_output_backpressure();
      logic [CMD_W-1:0] cmd;
      idle_on      = 1'b0;
      hold_off_req = 1'b1;
      for (int k = 0; k < 40; k++) begin
         cmd = (k % 4 == 3) ? CMD_PICK : CMD_ENQUEUE;
         send_item(cmd, pick_task_id(cmd), pick_deadline(), 0);
      end
      wait_reports_drained();
      idle_on = 1'b1;
   endtask

   task automatic test_random_traffic(input int n_items);
      logic [CMD_W-1:0] cmd;
      int r;
      bit filling;
      filling = 1'b1;
      for (int k = 0; k < n_items; k++) begin
         idle_on = !(k >= n_items / 2 && k < n_items / 2 + 80);
         if (ready_count == SLOTS) filling = 1'b0;
         else if (ready_count == 0) filling = 1'b1;
         else if ($urandom_range(0, 99) < 3) filling = !filling;
         r = $urandom_range(0, 99);
         if (r < 5) cmd = CMD_UNUSED;
         else if (r < 30) cmd = CMD_PICK;
         else if (r < (filling ? 80 : 45)) cmd = CMD_ENQUEUE;
         else cmd = CMD_DEQUEUE;
         send_item(cmd, pick_task_id(cmd), pick_deadline(), sender_gap());
      end
      idle_on = 1'b1;
      wait_reports_drained();
   endtask

   task automatic test_drain_to_empty();
      while (ready_count > 0)
         send_item(CMD_DEQUEUE, ready_tid[$urandom_range(0, ready_count - 1)],
                   $urandom(), sender_gap());
      send_item(CMD_PICK, '1, '1, 0);
      wait_reports_drained();
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_command   = CMD_ENQUEUE;
      req_task_id   = '0;
      req_deadline  = '0;
      idle_on       = 1'b1;
      hold_off_req  = 1'b0;
      fail_count    = 0;
      ready_count   = 0;
      ready_nearest = NO_DEADLINE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_queue();
      test_fill_and_overflow();
      test_pick_order();
      test_output_backpressure();
      test_random_traffic(900);
      test_drain_to_empty();

      if (fail_count == 0 && pending_reports.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
